// ----- rtl/core/hckx_pkg.sv -----
// Package for the SHA-256 counter-mode keystream cipher.
// Holds the round constants, initial hash values, register indexes and helpers.
// Used by every module in rtl/core.
`default_nettype none
package hckx_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;
	localparam int unsigned QueueDepth = 4;

	localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SALT0 = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SALT1 = 3'd5;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam logic [31:0] MSG_BITS = 32'd416;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       new_block;
	} front_item_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/hckx_if.sv -----
// Valid/ready channel interfaces for data items and register writes.
// Depends on nothing.
`default_nettype none
interface hckx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;
	modport source(output valid, data_byte, end_of_message, input ready);
	modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface hckx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source(output valid, out_byte, out_last, input ready);
	modport sink(input valid, out_byte, out_last, output ready);
endinterface

interface hckx_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hckx_front.sv -----
// Front part: accepts bytes, tracks the byte offset and marks block starts.
// Depends on hckx_pkg.
`default_nettype none
module hckx_front
	import hckx_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hckx_byte_if.sink  in_ch,
	output front_item_t item,
	output logic       item_valid,
	input  wire logic  item_ready
);
	logic [4:0] offset_q;

	assign in_ch.ready = item_ready;
	assign item_valid = in_ch.valid;
	assign item.data = in_ch.data_byte;
	assign item.last = in_ch.end_of_message;
	assign item.new_block = (offset_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (in_ch.valid && item_ready) begin
			offset_q <= in_ch.end_of_message ? 5'd0 : offset_q + 5'd1;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/hckx_queue.sv -----
// Short item queue between the front and the back part.
// Depends on hckx_pkg.
`default_nettype none
module hckx_queue
	import hckx_pkg::*;
#(
	parameter int unsigned Depth = QueueDepth
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire front_item_t wr_item,
	input  wire logic   wr_valid,
	output logic        wr_ready,
	output front_item_t rd_item,
	output logic        rd_valid,
	input  wire logic   rd_ready
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	front_item_t        mem_q [Depth];
	logic [AW-1:0]      wp_q, rp_q;
	logic [AW:0]        cnt_q;
	logic               push, pop;

	assign wr_ready = (cnt_q != (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_item = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/hckx_back.sv -----
// Back part: one SHA-256 round per cycle per keystream block, then XOR and output.
// Depends on hckx_pkg and the channel interfaces.
`default_nettype none
module hckx_back
	import hckx_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic [255:0] key,
	input  wire logic [127:0] salt,
	input  wire front_item_t q_item,
	input  wire logic   q_valid,
	output logic        q_ready,
	hckx_out_if.source  out_ch
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HASH = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t       state_q;
	logic [5:0]   round_q;
	logic [31:0]  counter_q;
	logic [4:0]   off_q;
	logic [31:0]  w_q [16];
	logic [31:0]  v_q [8];
	logic [255:0] ks_q;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic         out_last_q;

	logic         out_free, take;
	logic [31:0]  wr, s0w, s1w, t1, t2, e, a;
	logic [7:0]   kbyte;

	assign out_free = !out_valid_q || out_ch.ready;
	assign take = (state_q == ST_IDLE) && q_valid && !q_item.new_block && out_free;
	assign q_ready = take;

	always_comb begin
		s0w = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1w = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wr = (round_q < 6'd16) ? w_q[0] : w_q[0] + s0w + w_q[9] + s1w;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
			+ ROUND_K[round_q] + wr;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		kbyte = ks_q[255 - 8*off_q -: 8];
	end

	// The schedule window shifts every round so word r always sits at index 0.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_item.new_block) begin
			for (int i = 0; i < 8; i++) begin
				w_q[i] <= key[255 - 32*i -: 32];
				v_q[i] <= INIT_H[i];
			end
			for (int i = 0; i < 4; i++) begin
				w_q[8+i] <= salt[127 - 32*i -: 32];
			end
			w_q[12] <= counter_q;
			w_q[13] <= PAD_WORD;
			w_q[14] <= '0;
			w_q[15] <= MSG_BITS;
		end else if (state_q == ST_HASH) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wr;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end else if (state_q == ST_FIN) begin
			for (int i = 0; i < 8; i++) begin
				ks_q[255 - 32*i -: 32] <= INIT_H[i] + v_q[i];
			end
		end
		if (take) begin
			out_byte_q <= q_item.data ^ kbyte;
			out_last_q <= q_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			counter_q <= '0;
			off_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.new_block) begin
						state_q <= ST_HASH;
						round_q <= '0;
					end
				end
				ST_HASH: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take) begin
				out_valid_q <= 1'b1;
				if (q_item.last) begin
					off_q <= '0;
					counter_q <= '0;
				end else begin
					off_q <= off_q + 5'd1;
					if (off_q == 5'd31) begin
						counter_q <= counter_q + 32'd1;
					end
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The block-start mark of the head item is cleared in the top level once hashing starts.
	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.out_last = out_last_q;

	property p_take_idle;
		@(posedge clk) disable iff (!arst_n) take |-> state_q == ST_IDLE;
	endproperty
	assert property (p_take_idle) else $error("item taken during hashing");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> $past(round_q) == 6'd63) else $error("short compression");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q) else $error("result dropped");
endmodule
`default_nettype wire

// ----- rtl/core/hash_counter_keystream_xor.sv -----
// Top level of the SHA-256 counter-mode keystream cipher.
// Depends on hckx_pkg, the channel interfaces, hckx_front, hckx_queue and hckx_back.
// Each byte is XORed with the next byte of SHA-256(key | salt | counter). The first byte of
// each 32-byte block waits for one compression at one round per cycle; the other 31 bytes
// need no compression. The key and salt are sampled when a block starts hashing; write
// them only while the block is idle.
`default_nettype none
module hash_counter_keystream_xor
	import hckx_pkg::*;
#(
	parameter int unsigned QDepth = QueueDepth
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hckx_byte_if.sink  in_ch,
	hckx_out_if.source out_ch,
	hckx_cfg_if.sink   cfg
);
	logic [255:0] key_q;
	logic [127:0] salt_q;
	front_item_t  f_item, q_item, q_item_fix;
	logic         f_valid, f_ready, q_valid, q_ready;
	logic         started_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			salt_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEY0: key_q[255:192] <= cfg.data;
				REG_KEY1: key_q[191:128] <= cfg.data;
				REG_KEY2: key_q[127:64] <= cfg.data;
				REG_KEY3: key_q[63:0] <= cfg.data;
				REG_SALT0: salt_q[127:64] <= cfg.data;
				REG_SALT1: salt_q[63:0] <= cfg.data;
				default: ;
			endcase
		end
	end

	// The block-start mark is dropped once its compression has begun.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (q_valid && q_ready) begin
			started_q <= 1'b0;
		end else if (q_valid && q_item.new_block) begin
			started_q <= 1'b1;
		end
	end

	always_comb begin
		q_item_fix = q_item;
		q_item_fix.new_block = q_item.new_block && !started_q;
	end

	hckx_front u_front (
		.clk, .arst_n, .in_ch,
		.item(f_item), .item_valid(f_valid), .item_ready(f_ready));

	hckx_queue #(.Depth(QDepth)) u_queue (
		.clk, .arst_n,
		.wr_item(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready));

	hckx_back u_back (
		.clk, .arst_n, .key(key_q), .salt(salt_q),
		.q_item(q_item_fix), .q_valid(q_valid), .q_ready(q_ready), .out_ch);
endmodule
`default_nettype wire

// ----- tb/sv/hash_counter_keystream_xor_tb.sv -----
// Testbench for the SHA-256 counter-mode keystream cipher.
// Depends on hckx_pkg, the channel interfaces and hash_counter_keystream_xor.
// Random and directed bytes are checked against a predictor with its own SHA-256.
`default_nettype none
module hash_counter_keystream_xor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hckx_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} cipher_item_t;

	localparam logic [31:0] H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] KR [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic clk;
	logic arst_n;
	hckx_byte_if in_ch();
	hckx_out_if out_ch();
	hckx_cfg_if cfg();

	hash_counter_keystream_xor u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	logic [63:0] key_regs [4];
	logic [63:0] salt_regs [2];
	logic [31:0] blk_count;
	logic [4:0] blk_offset;
	logic [31:0] ks_words [8];

	byte_item_t pending_bytes [$];
	cipher_item_t expected_cipher [$];
	int errors;
	int idle_pct;
	int cfg_pending;
	int dump;
	int n_msgs;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compute_keystream();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, t1, t2, a, b;
		for (int i = 0; i < 4; i++) begin
			w[2 * i] = key_regs[i][63:32];
			w[2 * i + 1] = key_regs[i][31:0];
		end
		w[8] = salt_regs[0][63:32];
		w[9] = salt_regs[0][31:0];
		w[10] = salt_regs[1][63:32];
		w[11] = salt_regs[1][31:0];
		w[12] = blk_count;
		w[13] = 32'h8000_0000;
		w[14] = 32'd0;
		w[15] = 32'd416;
		for (int i = 0; i < 8; i++) v[i] = H0[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				a = w[(r + 1) & 15];
				b = w[(r + 14) & 15];
				wr = w[r & 15] + (ror(a, 7) ^ ror(a, 18) ^ (a >> 3)) + w[(r + 9) & 15]
					+ (ror(b, 17) ^ ror(b, 19) ^ (b >> 10));
				w[r & 15] = wr;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[r] + wr;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) ks_words[i] = H0[i] + v[i];
	endtask

	task automatic predict_cipher(input byte_item_t it);
		cipher_item_t e;
		logic [31:0] word;
		if (blk_offset == 0) compute_keystream();
		word = ks_words[blk_offset[4:2]];
		e.out_byte = it.data_byte ^ word[8 * (3 - blk_offset[1:0]) +: 8];
		e.out_last = it.end_of_message;
		expected_cipher.push_back(e);
		if (it.end_of_message) begin
			blk_count = 0;
			blk_offset = 0;
		end else begin
			blk_offset = blk_offset + 5'd1;
			if (blk_offset == 0) blk_count = blk_count + 32'd1;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

	// Byte driver.
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			predict_cipher({in_ch.data_byte, in_ch.end_of_message});
		end
		if (!in_ch.valid || in_ch.ready) begin
			if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= pending_bytes[0].data_byte;
				in_ch.end_of_message <= pending_bytes[0].end_of_message;
				void'(pending_bytes.pop_front());
			end else begin
				in_ch.valid <= 1'b0;
				in_ch.data_byte <= 8'($urandom);
				in_ch.end_of_message <= 1'($urandom);
			end
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_cipher.size() == 0) begin
				$error("unexpected item: out_byte %h out_last %b", out_ch.out_byte,
					out_ch.out_last);
				errors++;
			end else begin
				if (out_ch.out_byte !== expected_cipher[0].out_byte) begin
					$error("out_byte expected %h actual %h", expected_cipher[0].out_byte,
						out_ch.out_byte);
					errors++;
				end
				if (out_ch.out_last !== expected_cipher[0].out_last) begin
					$error("out_last expected %b actual %b", expected_cipher[0].out_last,
						out_ch.out_last);
					errors++;
				end
				void'(expected_cipher.pop_front());
			end
		end
		out_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx <= REG_KEY3) key_regs[idx] = val;
		else if (idx <= REG_SALT1) salt_regs[idx - REG_SALT0] = val;
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_bytes.size() > 0 || in_ch.valid || expected_cipher.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [63:0] pick64(input int mode);
		case (mode)
			0: return 64'd0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_message(input int len, input int mode);
		byte_item_t it;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: it.data_byte = 8'h00;
				1: it.data_byte = 8'hFF;
				default: it.data_byte = 8'($urandom);
			endcase
			it.end_of_message = (i == len - 1);
			pending_bytes.push_back(it);
		end
	endtask

	initial begin
		errors = 0;
		idle_pct = 31;
		blk_count = 0;
		blk_offset = 0;
		for (int i = 0; i < 4; i++) key_regs[i] = '0;
		for (int i = 0; i < 2; i++) salt_regs[i] = '0;
		for (int i = 0; i < 8; i++) ks_words[i] = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.end_of_message = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_KEY0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset (all-zero) registers, then all-ones registers, two messages each.
		queue_message(3, 0);
		queue_message(2, 1);
		drain();
		for (int i = 0; i < 6; i++) write_reg(3'(i), '1);
		// Out-of-range indexes must be ignored.
		write_reg(3'd6, 64'h0123_4567_89ab_cdef);
		write_reg(3'd7, 64'hfedc_ba98_7654_3210);
		queue_message(5, 1);
		queue_message(4, 2);
		drain();
		for (int i = 0; i < 6; i++) write_reg(3'(i), pick64(2));
		// Crosses a block boundary.
		queue_message(40, 2);
		drain();

		n_msgs = 0;
		while (n_msgs < 600) begin
			dump = $urandom_range(9);
			idle_pct = (n_msgs > 250 && n_msgs < 400) ? 0 : 31;
			if (dump < 3) begin
				for (int i = 0; i < 4; i++) write_reg(3'(i), pick64($urandom_range(6)));
			end
			write_reg(REG_SALT0, pick64($urandom_range(6)));
			write_reg(REG_SALT1, pick64($urandom_range(6)));
			if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 6)), pick64(2));
			cfg_pending = ($urandom_range(9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
			queue_message(cfg_pending, 2);
			n_msgs += cfg_pending;
			drain();
		end
		idle_pct = 31;

		// Wrap of the block counter is out of reach in a run of this length.
		drain();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
